[hdl/ttcg_pkg.sv]
// ----------------------------------------------------------------------------
// ttcg_pkg
// Shared types and constants for the thermal throttle and core gate block.
// ----------------------------------------------------------------------------
package ttcg_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_FLOOR     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOT_MARGIN         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_HOT_CAP       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_WARM_CAP      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_UNTHROTTLED   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CORE_GATING_ENABLE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CORE0_OFF_PERMIT   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CAPS_USER_CHANGED  = 3'd7;

	// reset values
	localparam logic [6:0]  RST_THROTTLE_FLOOR   = 7'd55;
	localparam logic [2:0]  RST_HOT_MARGIN       = 3'd5;
	localparam logic [31:0] RST_FREQ_HOT_CAP     = 32'd800000;
	localparam logic [31:0] RST_FREQ_WARM_CAP    = 32'd1113600;
	localparam logic [31:0] RST_FREQ_UNTHROTTLED = 32'hFFFF_FFFF;
	localparam logic [31:0] RST_CURRENT_CAP      = 32'hFFFF_FFFF;

	// cap release point sits this many degrees under the threshold
	localparam logic signed [9:0] RELEASE_MARGIN = 10'sd5;

	typedef struct packed {
		logic [6:0]  throttle_floor;
		logic [2:0]  hot_margin;
		logic [31:0] freq_hot_cap;
		logic [31:0] freq_warm_cap;
		logic [31:0] freq_unthrottled;
		logic        core_gating_enable;
		logic        core0_off_permit;
		logic        caps_user_changed;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  online_request;
		logic [31:0] freq_cap;
		logic        cap_changed;
		logic        is_throttling;
		logic        cap_writes_locked;
	} res_t;

endpackage

[hdl/ttcg_cfg.sv]
// ----------------------------------------------------------------------------
// ttcg_cfg
// Configuration register file; cap writes are refused while core 0 lock is set.
// ----------------------------------------------------------------------------
module ttcg_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ttcg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ttcg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               lock,
	output ttcg_pkg::cfg_t                     cfg
);
	import ttcg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.throttle_floor     <= RST_THROTTLE_FLOOR;
			cfg_q.hot_margin         <= RST_HOT_MARGIN;
			cfg_q.freq_hot_cap       <= RST_FREQ_HOT_CAP;
			cfg_q.freq_warm_cap      <= RST_FREQ_WARM_CAP;
			cfg_q.freq_unthrottled   <= RST_FREQ_UNTHROTTLED;
			cfg_q.core_gating_enable <= 1'b1;
			cfg_q.core0_off_permit   <= 1'b0;
			cfg_q.caps_user_changed  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THROTTLE_FLOOR:     cfg_q.throttle_floor <= cfg_wdata[6:0];
				REG_HOT_MARGIN:         cfg_q.hot_margin <= cfg_wdata[2:0];
				REG_FREQ_HOT_CAP:       if (!lock) cfg_q.freq_hot_cap <= cfg_wdata;
				REG_FREQ_WARM_CAP:      if (!lock) cfg_q.freq_warm_cap <= cfg_wdata;
				REG_FREQ_UNTHROTTLED:   cfg_q.freq_unthrottled <= cfg_wdata;
				REG_CORE_GATING_ENABLE: cfg_q.core_gating_enable <= cfg_wdata[0];
				REG_CORE0_OFF_PERMIT:   cfg_q.core0_off_permit <= cfg_wdata[0];
				REG_CAPS_USER_CHANGED:  cfg_q.caps_user_changed <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/ttcg_core.sv]
// ----------------------------------------------------------------------------
// ttcg_core
// Band rules, core 0 rule and cap hysteresis for one sample; holds the
// throttle, cap and lock state.
// ----------------------------------------------------------------------------
module ttcg_core #(
	parameter int NUM_CORES = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ttcg_pkg::cfg_t       cfg,
	input  logic                 upd,
	input  logic signed [7:0]    temperature,
	input  logic [7:0]           online_now,
	output ttcg_pkg::res_t       res,
	output logic                 lock
);
	import ttcg_pkg::*;

	localparam logic [7:0] ALL_MASK =
		(NUM_CORES >= 8) ? 8'hFF : 8'(({8'd0, 8'd1} << NUM_CORES) - 16'd1);

	logic        throttle_q;
	logic [31:0] cap_q;
	logic        lock_q;

	logic              lock_d;
	logic [7:0]        m0;
	logic [7:0]        m;
	logic              may_drop;
	logic signed [9:0] t_w, thr_w, hot_w, rel_w;
	logic              throttle_d;
	logic [31:0]       cap_d;

	always_comb begin
		lock_d = lock_q;
		m0 = online_now;
		if (!online_now[0]) begin
			lock_d = 1'b1;
			if (!cfg.core0_off_permit) m0[0] = 1'b1;
		end
	end

	assign may_drop = cfg.core0_off_permit && !cfg.caps_user_changed;

	always_comb begin
		m = m0;
		if (cfg.core_gating_enable) begin
			if (NUM_CORES == 8) begin
				if (temperature > 8'sd80) begin
					m = m & ~8'hCE;
					if (may_drop) m[0] = 1'b0;
				end else if (temperature > 8'sd55 && temperature <= 8'sd65) begin
					m = (m | 8'hC0) & ~8'h0E;
					if (may_drop) m[0] = 1'b0;
				end else if (temperature > 8'sd45 && temperature <= 8'sd50) begin
					m = (m | 8'h03) & ~8'h0C;
				end else if (temperature == 8'sd40) begin
					m = m | ALL_MASK;
				end
			end else if (NUM_CORES == 4) begin
				if (temperature > 8'sd80) begin
					m = m & ~8'h0E;
				end else if (temperature > 8'sd70 && temperature <= 8'sd75) begin
					m = (m | 8'h02) & ~8'h0C;
				end else if (temperature > 8'sd60 && temperature <= 8'sd65) begin
					m = (m | 8'h04) & ~8'h08;
				end else if (temperature == 8'sd55) begin
					m = m | ALL_MASK;
				end
			end
		end
	end

	// cap hysteresis in 10-bit signed so a low threshold releases below zero
	assign t_w   = {{2{temperature[7]}}, temperature};
	assign thr_w = signed'({3'b000, cfg.throttle_floor});
	assign hot_w = thr_w + signed'({7'd0, cfg.hot_margin});
	assign rel_w = thr_w - RELEASE_MARGIN;

	always_comb begin
		throttle_d = throttle_q;
		cap_d      = cap_q;
		if (throttle_q && t_w < rel_w) begin
			cap_d      = cfg.freq_unthrottled;
			throttle_d = 1'b0;
		end else if (t_w >= hot_w) begin
			cap_d      = cfg.freq_hot_cap;
			throttle_d = 1'b1;
		end else if (t_w > thr_w) begin
			cap_d      = cfg.freq_warm_cap;
			throttle_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			throttle_q <= 1'b0;
			cap_q      <= RST_CURRENT_CAP;
			lock_q     <= 1'b0;
		end else if (upd) begin
			throttle_q <= throttle_d;
			cap_q      <= cap_d;
			lock_q     <= lock_d;
		end
	end

	assign res.online_request    = m;
	assign res.freq_cap          = cap_d;
	assign res.cap_changed       = (cap_d != cap_q);
	assign res.is_throttling     = throttle_d;
	assign res.cap_writes_locked = lock_d;
	assign lock = lock_q;

`ifndef SYNTHESIS
	a_lock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		lock_q |=> lock_q)
		else $error("core 0 lock cleared without reset");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> ($stable(cap_q) && $stable(throttle_q) && $stable(lock_q)))
		else $error("state moved with no sample");

	a_throttle_cap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(throttle_q) |->
			(cap_q == $past(cfg.freq_hot_cap) || cap_q == $past(cfg.freq_warm_cap)))
		else $error("throttle entered without hot or warm cap");

	a_release_cap: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(throttle_q) |-> (cap_q == $past(cfg.freq_unthrottled)))
		else $error("throttle released without unthrottled cap");
`endif

endmodule

[hdl/thermal_throttle_and_core_gate.sv]
// ----------------------------------------------------------------------------
// thermal_throttle_and_core_gate
// Per-tick core online request and frequency cap from a temperature sample.
//
//   channel  signals                                     direction
//   in       in_valid, in_stall, temperature, online_now  request in
//   out      out_valid, out_stall, online_request,        result out
//            freq_cap, cap_changed, is_throttling,
//            cap_writes_locked
//   cfg      cfg_we, cfg_index, cfg_wdata                 register write
//
// One request per cycle while in_stall is low; a request passes through the input register, then the result register.
// Band compares and cap select sit between the two registers; state updates
// when a request moves into the result register.
// Reset sets the configuration and state registers to their defaults and empties both stages.
// in_stall rises only when both stages are full and out_stall is high.
// ----------------------------------------------------------------------------
module thermal_throttle_and_core_gate #(
	parameter int NUM_CORES = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [7:0]                temperature,
	input  logic [7:0]                       online_now,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       online_request,
	output logic [31:0]                      freq_cap,
	output logic                             cap_changed,
	output logic                             is_throttling,
	output logic                             cap_writes_locked,
	input  logic                             cfg_we,
	input  logic [ttcg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ttcg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import ttcg_pkg::*;

	cfg_t cfg;
	res_t res;
	logic lock;

	logic              v_s1, v_s2;
	logic signed [7:0] temp_s1;
	logic [7:0]        mask_s1;
	res_t              res_s2;
	logic              adv1;

	assign adv1     = v_s1 && (!v_s2 || !out_stall);
	assign in_stall = v_s1 && !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (!in_stall) v_s1 <= in_valid;
			if (adv1) v_s2 <= 1'b1;
			else if (!out_stall) v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			temp_s1 <= temperature;
			mask_s1 <= online_now;
		end
		if (adv1) res_s2 <= res;
	end

	ttcg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.lock      (lock),
		.cfg       (cfg)
	);

	ttcg_core #(
		.NUM_CORES (NUM_CORES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.upd         (adv1),
		.temperature (temp_s1),
		.online_now  (mask_s1),
		.res         (res),
		.lock        (lock)
	);

	assign out_valid         = v_s2;
	assign online_request    = res_s2.online_request;
	assign freq_cap          = res_s2.freq_cap;
	assign cap_changed       = res_s2.cap_changed;
	assign is_throttling     = res_s2.is_throttling;
	assign cap_writes_locked = res_s2.cap_writes_locked;

`ifndef SYNTHESIS
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 |=> out_valid)
		else $error("request advanced but no result shown");

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && out_stall))
		else $error("input stalled with room in the pipe");

	a_no_stall_when_s2_free: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !v_s2) |-> !in_stall)
		else $error("input stalled while result stage empty");
`endif

endmodule
